[sv/pee_pkg.sv]
// shared types and constants for the postfix expression evaluator
// no dependencies; imported by every module of the block
package pee_pkg;

  localparam int STACK_DEPTH_D = 16;
  localparam int VALUE_WIDTH_D = 32;
  localparam int SYMBOL_W      = 8;
  localparam int STATUS_W      = 3;
  localparam int OUT_VALUE_W   = 32;
  // status, top_value, final_value packed, padded to whole bytes
  localparam int OUT_FIELDS_W  = STATUS_W + 2 * OUT_VALUE_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYMBOL_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYMBOL_W-1:0] CH_CR    = 8'h0D;
  localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DIV0    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_UNDER   = 3'd3,
    ST_OVER    = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  // request from the sequencer to the multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } arith_ctrl_t;

endpackage

[sv/pee_stack_mem.sv]
// operand stack storage: one write port, two registered read ports
// uses pee_pkg for default sizes
module pee_stack_mem import pee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_D,
  parameter int VALUE_WIDTH = VALUE_WIDTH_D,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [AW-1:0]          ra_addr,
  input  logic [AW-1:0]          rb_addr,
  output logic [VALUE_WIDTH-1:0] ra_data,
  output logic [VALUE_WIDTH-1:0] rb_data
);

  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[sv/pee_arith.sv]
// iterative multiply (shift and add) and signed divide (restoring), one bit a cycle
// uses pee_pkg for the control struct and default widths
module pee_arith import pee_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_D
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  arith_ctrl_t            ctrl,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          is_div_r, is_div_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [W-1:0]  op_r, op_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {acc_r, sh_r[W-1]};
  assign diff  = trial - {1'b0, op_r};
  assign ge    = (trial >= {1'b0, op_r});

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    sh_nxt     = sh_r;
    op_nxt     = op_r;
    if (ctrl.start) begin
      busy_nxt   = 1'b1;
      is_div_nxt = ctrl.is_div;
      cnt_nxt    = CW'(W - 1);
      acc_nxt    = '0;
      if (ctrl.is_div) begin
        // work on magnitudes, fix the sign at the end
        sh_nxt  = left[W-1] ? W'(-left) : left;
        op_nxt  = right[W-1] ? W'(-right) : right;
        neg_nxt = left[W-1] ^ right[W-1];
      end else begin
        sh_nxt  = left;
        op_nxt  = right;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (is_div_r) begin
        acc_nxt = ge ? diff[W-1:0] : trial[W-1:0];
        sh_nxt  = {sh_r[W-2:0], ge};
      end else begin
        if (op_r[0]) begin
          acc_nxt = acc_r + sh_r;
        end
        sh_nxt = {sh_r[W-2:0], 1'b0};
        op_nxt = {1'b0, op_r[W-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    op_r     <= op_nxt;
  end

  assign done   = done_r;
  assign result = !is_div_r ? acc_r : (neg_r ? W'(-sh_r) : sh_r);

endmodule

[sv/postfix_expression_evaluator.sv]
// postfix expression evaluator: one result word per symbol word
// a symbol passes S_EXEC and S_DONE, with S_ARITH between them for * and a non-zero /
// on the bit-serial unit, or S_TOPRD for an unknown symbol with three or more operands
// one symbol in flight; in_tready rises in the same cycle as out_tvalid, and no new word
// is taken before then; S_DONE waits while a result word is held by out_tready low
// synchronous active-low reset empties the stack and clears the abort flag
module postfix_expression_evaluator import pee_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_D,
  parameter int VALUE_WIDTH = VALUE_WIDTH_D
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SYMBOL_W-1:0]    in_tdata,   // symbol
  input  logic                   in_tlast,   // end_of_expression
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status, top_value, final_value, zero pad
  output logic                   out_tlast,  // done_res
  output logic                   out_tuser   // final_ok
);

  localparam int W    = VALUE_WIDTH;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TOPRD,
    S_ARITH,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_DIGIT,
    K_SPACE,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_OTHER
  } kind_t;

  state_t                 state_r, state_nxt;
  logic [CNTW-1:0]        count_r, count_nxt;
  logic                   aborted_r, aborted_nxt;
  logic [SYMBOL_W-1:0]    sym_r, sym_nxt;
  logic                   last_r, last_nxt;
  status_t                status_r, status_nxt;
  logic [W-1:0]           top_r, top_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tlast_r, out_tlast_nxt;
  logic                   out_tuser_r, out_tuser_nxt;

  kind_t                  kind;
  logic                   in_accept;
  logic                   out_load;
  logic                   final_ok;
  logic [OUT_VALUE_W-1:0] top_ext;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [W-1:0]           mem_wdata;
  logic [AW-1:0]          ra_addr;
  logic [AW-1:0]          rb_addr;
  logic [W-1:0]           ra_data;
  logic [W-1:0]           rb_data;

  arith_ctrl_t            arith_ctrl;
  logic                   arith_done;
  logic [W-1:0]           arith_result;

  pee_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  pee_arith #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (arith_ctrl),
    .left   (rb_data),
    .right  (ra_data),
    .done   (arith_done),
    .result (arith_result)
  );

  always_comb begin
    case (sym_r) inside
      [CH_ZERO:CH_NINE]:       kind = K_DIGIT;
      [CH_TAB:CH_CR], CH_SPACE: kind = K_SPACE;
      CH_PLUS:                 kind = K_ADD;
      CH_MINUS:                kind = K_SUB;
      CH_STAR:                 kind = K_MUL;
      CH_SLASH:                kind = K_DIV;
      default:                 kind = K_OTHER;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign top_ext   = OUT_VALUE_W'(signed'(top_r));
  assign final_ok  = last_r && !aborted_r && (count_r == CNTW'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    aborted_nxt    = aborted_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    status_nxt     = status_r;
    top_nxt        = top_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(count_r);
    mem_wdata      = top_r;
    // top and the entry below it are read on accept
    ra_addr        = AW'(count_r - 1'b1);
    rb_addr        = AW'(count_r - CNTW'(2));
    arith_ctrl     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          sym_nxt   = in_tdata;
          last_nxt  = in_tlast;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt  = S_DONE;
        status_nxt = ST_OK;
        top_nxt    = (count_r == '0) ? '0 : ra_data;
        if (aborted_r) begin
          status_nxt = ST_IGNORED;
        end else if (kind == K_DIGIT) begin
          if (count_r == CNTW'(STACK_DEPTH)) begin
            status_nxt  = ST_OVER;
            aborted_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_r);
            mem_wdata = W'(sym_r[3:0]);
            top_nxt   = W'(sym_r[3:0]);
            count_nxt = count_r + 1'b1;
          end
        end else if (kind == K_SPACE) begin
          status_nxt = ST_OK;
        end else if (count_r < CNTW'(2)) begin
          status_nxt  = ST_UNDER;
          aborted_nxt = 1'b1;
        end else begin
          mem_waddr = AW'(count_r - CNTW'(2));
          count_nxt = count_r - 1'b1;
          case (kind)
            K_ADD: begin
              mem_we    = 1'b1;
              mem_wdata = rb_data + ra_data;
              top_nxt   = rb_data + ra_data;
            end
            K_SUB: begin
              mem_we    = 1'b1;
              mem_wdata = rb_data - ra_data;
              top_nxt   = rb_data - ra_data;
            end
            K_MUL: begin
              arith_ctrl = '{start: 1'b1, is_div: 1'b0};
              state_nxt  = S_ARITH;
            end
            K_DIV: begin
              if (ra_data == '0) begin
                mem_we     = 1'b1;
                mem_wdata  = '0;
                top_nxt    = '0;
                status_nxt = ST_DIV0;
              end else begin
                arith_ctrl = '{start: 1'b1, is_div: 1'b1};
                state_nxt  = S_ARITH;
              end
            end
            default: begin
              // unknown symbol drops both operands; the new top needs another read unless none are left
              status_nxt = ST_UNKNOWN;
              count_nxt  = count_r - CNTW'(2);
              if (count_r == CNTW'(2)) begin
                top_nxt = '0;
              end else begin
                ra_addr   = AW'(count_r - CNTW'(3));
                state_nxt = S_TOPRD;
              end
            end
          endcase
        end
      end

      S_TOPRD: begin
        top_nxt   = ra_data;
        state_nxt = S_DONE;
      end

      S_ARITH: begin
        if (arith_done) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(count_r - 1'b1);
          mem_wdata = arith_result;
          top_nxt   = arith_result;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({(final_ok ? top_ext : {OUT_VALUE_W{1'b0}}),
                                         top_ext, status_r});
          out_tlast_nxt  = last_r;
          out_tuser_nxt  = final_ok;
          if (last_r) begin
            count_nxt   = '0;
            aborted_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      aborted_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      aborted_r    <= aborted_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    status_r    <= status_nxt;
    top_r       <= top_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_write_aborted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && aborted_r) |-> !mem_we)
    else $error("stack written while expression aborted");

  a_arith_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    arith_done |-> state_r == S_ARITH)
    else $error("arith unit finished outside its wait state");

  a_final_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |->
      (out_tlast_r && (out_tdata_r[STATUS_W-1:0] == ST_OK ||
                       out_tdata_r[STATUS_W-1:0] == ST_DIV0 ||
                       out_tdata_r[STATUS_W-1:0] == ST_UNKNOWN)))
    else $error("final_ok on a word that is not a clean last word");

  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (count_r == '0 && !aborted_r))
    else $error("stack not cleared after last symbol");

endmodule

[tb/postfix_expression_evaluator_tb.sv]
// self-checking testbench for the postfix expression evaluator: a directed table, then random
// expressions, checked word by word against an evaluator written here in plain sv
// depends on pee_pkg and postfix_expression_evaluator
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb;
  import pee_pkg::*;

  localparam int DEPTH          = STACK_DEPTH_D;
  localparam int RANDOM_WORDS   = 1525;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_WORDS    = 150;
  localparam int TABLE_ROWS     = 25;

  typedef struct packed {
    status_t     status;
    logic [31:0] top;
    logic        done;
    logic        fin_ok;
    logic [31:0] fin_val;
  } eval_result_t;

  typedef struct packed {
    logic [7:0]  sym;
    logic        last;
    logic        typed;
    status_t     status;
    logic [31:0] top;
    logic        fin_ok;
    logic [31:0] fin_val;
  } table_row_t;

  // typed rows carry the result as it reads off directly; the rest go to the evaluator
  localparam table_row_t DIRECTED_ROWS [TABLE_ROWS] = '{
    '{8'h00,             1'b1, 1'b1, ST_UNDER,   32'd0, 1'b0, 32'd0},
    '{CH_NINE,           1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO,           1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_SLASH,          1'b0, 1'b1, ST_DIV0,    32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd7,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_PLUS,           1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd3,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_MINUS,          1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd6,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_STAR,           1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_TAB,            1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd5,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_SLASH,          1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd8,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd2,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{8'hFF,             1'b0, 1'b1, ST_UNKNOWN, 32'd4, 1'b0, 32'd0},
    '{CH_CR,             1'b1, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_PLUS,           1'b0, 1'b1, ST_UNDER,   32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd1,    1'b0, 1'b1, ST_IGNORED, 32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd1,    1'b1, 1'b1, ST_IGNORED, 32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd1,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd8,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_MINUS,          1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_ZERO + 8'd3,    1'b0, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0},
    '{CH_SLASH,          1'b1, 1'b0, ST_OK,      32'd0, 1'b0, 32'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SYMBOL_W-1:0]    in_tdata;   // symbol
  logic                   in_tlast;   // end_of_expression
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, top_value, final_value, zero pad
  logic                   out_tlast;  // done_res
  logic                   out_tuser;  // final_ok

  logic [31:0]  rpn_stack [DEPTH];
  int unsigned  rpn_depth;
  bit           rpn_aborted;

  eval_result_t pending_reports [$];
  eval_result_t oldest_report;
  logic [7:0]   expr_q [$];
  int unsigned  words_accepted;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  mismatch_count;
  int unsigned  quiet_cycles;

  postfix_expression_evaluator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // signed division truncating toward zero; the most negative value over -1 wraps to itself
  function automatic logic [31:0] trunc_div(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] quo;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    quo = mag_n / mag_d;
    return (num[31] ^ den[31]) ? -quo : quo;
  endfunction

  function automatic eval_result_t evaluate_symbol(input logic [7:0] sym, input logic last);
    eval_result_t res;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  val;
    status_t      st;
    st = ST_OK;
    val = '0;
    if (rpn_aborted) begin
      st = ST_IGNORED;
    end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
      if (rpn_depth >= DEPTH) begin
        rpn_aborted = 1'b1;
        st = ST_OVER;
      end else begin
        rpn_stack[rpn_depth] = {24'd0, sym - CH_ZERO};
        rpn_depth++;
      end
    end else if (sym == CH_SPACE || (sym >= CH_TAB && sym <= CH_CR)) begin
      st = ST_OK;
    end else if (rpn_depth < 2) begin
      rpn_aborted = 1'b1;
      st = ST_UNDER;
    end else begin
      rhs = rpn_stack[rpn_depth-1];
      lhs = rpn_stack[rpn_depth-2];
      rpn_depth -= 2;
      case (sym)
        CH_PLUS:  val = lhs + rhs;
        CH_MINUS: val = lhs - rhs;
        CH_STAR:  val = lhs * rhs;
        CH_SLASH: begin
          if (rhs == '0) begin
            st = ST_DIV0;
          end else begin
            val = trunc_div(lhs, rhs);
          end
        end
        default:  st = ST_UNKNOWN;
      endcase
      // an unknown symbol only discards its two operands
      if (st != ST_UNKNOWN) begin
        rpn_stack[rpn_depth] = val;
        rpn_depth++;
      end
    end
    res.status  = st;
    res.top     = (rpn_depth == 0) ? '0 : rpn_stack[rpn_depth-1];
    res.done    = last;
    res.fin_ok  = 1'b0;
    res.fin_val = '0;
    if (last) begin
      if (!rpn_aborted && rpn_depth == 1) begin
        res.fin_ok  = 1'b1;
        res.fin_val = rpn_stack[0];
      end
      rpn_depth   = 0;
      rpn_aborted = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [7:0] digit_sym(input int unsigned v);
    return CH_ZERO + v[7:0];
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_blank();
    int unsigned pick;
    pick = $urandom_range(5);
    return (pick == 5) ? CH_SPACE : CH_TAB + pick[7:0];
  endfunction

  // well-formed postfix with n_vals operands, whitespace sprinkled in
  function automatic void build_rpn(input int unsigned n_vals);
    int unsigned pushed;
    int unsigned held;
    pushed = 0;
    held = 0;
    expr_q.delete();
    while (pushed < n_vals || held > 1) begin
      if ($urandom_range(9) == 0) expr_q.push_back(random_blank());
      if (pushed < n_vals && (held < 2 || $urandom_range(1) == 1)) begin
        expr_q.push_back(digit_sym($urandom_range(9)));
        pushed++;
        held++;
      end else begin
        expr_q.push_back(random_op());
        held--;
      end
    end
    if ($urandom_range(9) == 0) expr_q.push_back(random_blank());
  endfunction

  // long product chains drive the value through wrap-around and the sign bit
  function automatic void build_chain();
    expr_q.delete();
    if ($urandom_range(1) == 1) begin
      // 8^10 * 2 lands exactly on the most negative value
      expr_q.push_back(digit_sym(8));
      repeat (9) begin
        expr_q.push_back(digit_sym(8));
        expr_q.push_back(CH_STAR);
      end
      expr_q.push_back(digit_sym(2));
      expr_q.push_back(CH_STAR);
    end else begin
      expr_q.push_back(digit_sym($urandom_range(2, 9)));
      repeat ($urandom_range(6, 13)) begin
        expr_q.push_back(digit_sym($urandom_range(2, 9)));
        expr_q.push_back(CH_STAR);
      end
    end
    case ($urandom_range(3))
      0: begin
        // divide by minus one
        expr_q.push_back(CH_ZERO);
        expr_q.push_back(digit_sym(1));
        expr_q.push_back(CH_MINUS);
        expr_q.push_back(CH_SLASH);
      end
      1: begin
        expr_q.push_back(digit_sym($urandom_range(9)));
        expr_q.push_back(random_op());
      end
      default: ;
    endcase
  endfunction

  // fill the stack to around its depth, past it in some runs
  function automatic void build_deep();
    int unsigned n_vals;
    n_vals = $urandom_range(DEPTH - 2, DEPTH + 2);
    expr_q.delete();
    repeat (n_vals) expr_q.push_back(digit_sym($urandom_range(9)));
    repeat (n_vals - 1) expr_q.push_back(random_op());
  endfunction

  function automatic void build_broken();
    int unsigned pos;
    build_rpn($urandom_range(2, 7));
    pos = $urandom_range(expr_q.size() - 1);
    case ($urandom_range(2))
      0:       expr_q[pos] = 8'($urandom_range(255));
      1:       expr_q.delete(expr_q.size() - 1);
      default: expr_q.push_back(random_op());
    endcase
    if (expr_q.size() == 0) expr_q.push_back(random_op());
  endfunction

  function automatic void build_noise();
    expr_q.delete();
    repeat ($urandom_range(1, 8)) expr_q.push_back(8'($urandom_range(255)));
  endfunction

  // rotate through the idling phases every PHASE_WORDS (150) words
  function automatic void set_idle_phase();
    case ((words_accepted / PHASE_WORDS) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endfunction

  task automatic send_word(input logic [7:0] sym, input logic last);
    set_idle_phase();
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_accepted++;
    pending_reports.push_back(evaluate_symbol(sym, last));
  endtask

  task automatic send_expression();
    for (int i = 0; i < expr_q.size(); i++) begin
      send_word(expr_q[i], i == expr_q.size() - 1);
    end
  endtask

  initial begin
    int unsigned pick;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    rpn_depth      = 0;
    rpn_aborted    = 1'b0;
    words_accepted = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < TABLE_ROWS; r++) begin
      send_word(DIRECTED_ROWS[r].sym, DIRECTED_ROWS[r].last);
      if (DIRECTED_ROWS[r].typed) begin
        pending_reports[pending_reports.size() - 1] = '{DIRECTED_ROWS[r].status,
            DIRECTED_ROWS[r].top, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].fin_ok,
            DIRECTED_ROWS[r].fin_val};
      end
    end

    while (words_accepted < TABLE_ROWS + RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 55) build_rpn(($urandom_range(3) == 0) ? $urandom_range(7, 12)
                                                          : $urandom_range(1, 6));
      else if (pick < 65) build_chain();
      else if (pick < 73) build_deep();
      else if (pick < 88) build_broken();
      else build_noise();
      send_expression();
    end
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $error("result word with none awaited: tdata %0h", out_tdata);
      end else begin
        oldest_report = pending_reports.pop_front();
        compare_field("status", 32'(oldest_report.status), 32'(out_tdata[STATUS_W-1:0]));
        compare_field("top_value", oldest_report.top, out_tdata[STATUS_W +: OUT_VALUE_W]);
        compare_field("done_res", 32'(oldest_report.done), 32'(out_tlast));
        compare_field("final_ok", 32'(oldest_report.fin_ok), 32'(out_tuser));
        compare_field("final_value", oldest_report.fin_val,
                      out_tdata[STATUS_W + OUT_VALUE_W +: OUT_VALUE_W]);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // a long stretch with no word moving on either side means the block has hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
